@@ rtl/oag_pkg.sv @@
// ----------------------------------------------------------------------------
// oag_pkg
// Shared types, constants and helpers of the orientation address generator.
// ----------------------------------------------------------------------------
package oag_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int SAMPLE_W  = 16;
	localparam int PITCH_W   = 16;
	localparam int ADDR_W    = 28;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ENABLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_AXIS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ROW_PITCH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SAMPLE = 3'd6;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic AXIS_ROWS = 1'b0;

	typedef struct packed {
		logic [DIM_W-1:0]   plane_width;
		logic [DIM_W-1:0]   plane_height;
		logic               mirror_enable;
		logic               mirror_axis;
		logic [1:0]         rotation;
		logic [PITCH_W-1:0] dest_row_pitch;
		logic [1:0]         bytes_per_sample;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               last;
	} pos_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ rtl/oag_position.sv @@
// ----------------------------------------------------------------------------
// oag_position
// Column and row counters with the mirror and rotation mapping of each sample.
// ----------------------------------------------------------------------------
module oag_position (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  oag_pkg::cfg_t cfg,
	output oag_pkg::pos_t pos
);

	logic [oag_pkg::COORD_W-1:0] column_count_q;
	logic [oag_pkg::COORD_W-1:0] row_count_q;
	logic [oag_pkg::DIM_W-1:0]   w;
	logic [oag_pkg::DIM_W-1:0]   h;
	logic [oag_pkg::COORD_W-1:0] wm1;
	logic [oag_pkg::COORD_W-1:0] hm1;
	logic [oag_pkg::COORD_W-1:0] col;
	logic [oag_pkg::COORD_W-1:0] row;
	logic [oag_pkg::COORD_W-1:0] x;
	logic [oag_pkg::COORD_W-1:0] y;
	logic                        col_end;
	logic                        row_end;

	always_comb begin
		w   = oag_pkg::clamp_dim(cfg.plane_width);
		h   = oag_pkg::clamp_dim(cfg.plane_height);
		wm1 = oag_pkg::COORD_W'(w - oag_pkg::DIM_W'(1));
		hm1 = oag_pkg::COORD_W'(h - oag_pkg::DIM_W'(1));
		col = ({1'b0, column_count_q} >= w) ? '0 : column_count_q;
		row = ({1'b0, row_count_q} >= h) ? '0 : row_count_q;
		x = col;
		y = row;
		if (cfg.mirror_enable) begin
			if (cfg.mirror_axis == oag_pkg::AXIS_ROWS) begin
				y = hm1 - row;
			end else begin
				x = wm1 - col;
			end
		end
		case (cfg.rotation)
			oag_pkg::ROT_90: begin
				pos.dest_x = y;
				pos.dest_y = wm1 - x;
			end
			oag_pkg::ROT_180: begin
				pos.dest_x = wm1 - x;
				pos.dest_y = hm1 - y;
			end
			oag_pkg::ROT_270: begin
				pos.dest_x = hm1 - y;
				pos.dest_y = x;
			end
			default: begin
				pos.dest_x = x;
				pos.dest_y = y;
			end
		endcase
		col_end  = (col == wm1);
		row_end  = (row == hm1);
		pos.last = col_end && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (advance) begin
			if (col_end) begin
				column_count_q <= '0;
				row_count_q    <= row_end ? '0 : row + oag_pkg::COORD_W'(1);
			end else begin
				column_count_q <= col + oag_pkg::COORD_W'(1);
				row_count_q    <= row;
			end
		end
	end

endmodule

@@ rtl/oag_address.sv @@
// ----------------------------------------------------------------------------
// oag_address
// Destination byte address from row pitch, destination row and column, the column scaled by the sample size.
// ----------------------------------------------------------------------------
module oag_address (
	input  logic [oag_pkg::PITCH_W-1:0] dest_row_pitch,
	input  logic [1:0]                  bytes_per_sample,
	input  logic [oag_pkg::COORD_W-1:0] dest_x,
	input  logic [oag_pkg::COORD_W-1:0] dest_y,
	output logic [oag_pkg::ADDR_W-1:0]  dest_address
);

	logic [oag_pkg::ADDR_W-1:0]    row_offset;
	logic [oag_pkg::COORD_W:0]     col_offset;

	always_comb begin
		row_offset   = oag_pkg::ADDR_W'(dest_row_pitch) * oag_pkg::ADDR_W'(dest_y);
		col_offset   = bytes_per_sample[1] ? {dest_x, 1'b0} : {1'b0, dest_x};
		dest_address = row_offset + oag_pkg::ADDR_W'(col_offset);
	end

endmodule

@@ rtl/orientation_address_generator_unit.sv @@
// ----------------------------------------------------------------------------
// orientation_address_generator_unit
// Mirrors and rotates raster-order sample positions of one image plane and
// emits destination coordinates and byte addresses.
// ----------------------------------------------------------------------------
// The block takes one sample and gives one result per clock unless stalled.
// The first stage runs the column and row counters and the mirror and
// rotation mapping, the second stage forms the address with one 16 by 12 bit
// multiply. Both stages advance whenever the output register is empty or its
// result is being taken, so a stalled output holds at most two requests
// inside. The user writes configuration only while idle; it is not enforced.
module orientation_address_generator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oag_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [oag_pkg::SAMPLE_W-1:0]   pixel_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [oag_pkg::SAMPLE_W-1:0]   out_sample,
	output logic [oag_pkg::COORD_W-1:0]    dest_x,
	output logic [oag_pkg::COORD_W-1:0]    dest_y,
	output logic [oag_pkg::ADDR_W-1:0]     dest_address,
	output logic                           plane_done
);

	oag_pkg::cfg_t                 cfg_q;
	oag_pkg::pos_t                 pos;
	oag_pkg::pos_t                 pos_s1;
	logic [oag_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                          valid_s1;
	logic                          valid_s2;
	logic [oag_pkg::ADDR_W-1:0]    address;
	logic                          en_s1;
	logic                          en_s2;
	logic                          accept;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign accept   = in_valid && en_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_width      <= oag_pkg::DIM_W'(4096);
			cfg_q.plane_height     <= oag_pkg::DIM_W'(4096);
			cfg_q.mirror_enable    <= 1'b0;
			cfg_q.mirror_axis      <= 1'b0;
			cfg_q.rotation         <= oag_pkg::ROT_0;
			cfg_q.dest_row_pitch   <= oag_pkg::PITCH_W'(8192);
			cfg_q.bytes_per_sample <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				oag_pkg::REG_PLANE_WIDTH:
					cfg_q.plane_width <= cfg_data[oag_pkg::DIM_W-1:0];
				oag_pkg::REG_PLANE_HEIGHT:
					cfg_q.plane_height <= cfg_data[oag_pkg::DIM_W-1:0];
				oag_pkg::REG_MIRROR_ENABLE:    cfg_q.mirror_enable <= cfg_data[0];
				oag_pkg::REG_MIRROR_AXIS:      cfg_q.mirror_axis <= cfg_data[0];
				oag_pkg::REG_ROTATION:         cfg_q.rotation <= cfg_data[1:0];
				oag_pkg::REG_DEST_ROW_PITCH:   cfg_q.dest_row_pitch <= cfg_data;
				oag_pkg::REG_BYTES_PER_SAMPLE: cfg_q.bytes_per_sample <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	oag_position u_position (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg_q),
		.pos     (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1    <= pos;
			sample_s1 <= pixel_sample;
		end
	end

	oag_address u_address (
		.dest_row_pitch   (cfg_q.dest_row_pitch),
		.bytes_per_sample (cfg_q.bytes_per_sample),
		.dest_x           (pos_s1.dest_x),
		.dest_y           (pos_s1.dest_y),
		.dest_address     (address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			out_sample   <= sample_s1;
			dest_x       <= pos_s1.dest_x;
			dest_y       <= pos_s1.dest_y;
			dest_address <= address;
			plane_done   <= pos_s1.last;
		end
	end

endmodule

@@ rtl/oag_checker.sv @@
// ----------------------------------------------------------------------------
// oag_checker
// Port-level checks of the orientation address generator, bound to the top.
// ----------------------------------------------------------------------------
module oag_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [oag_pkg::SAMPLE_W-1:0]   out_sample,
	input logic [oag_pkg::COORD_W-1:0]    dest_x,
	input logic [oag_pkg::COORD_W-1:0]    dest_y,
	input logic [oag_pkg::ADDR_W-1:0]     dest_address,
	input logic                           plane_done
);

	// A result that is not taken keeps its sample, address and coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_address)
			&& $stable(dest_x) && $stable(dest_y) && $stable(plane_done)
			&& $stable(out_sample))
	else $error("stalled result changed");

	// No result is shown while reset is asserted.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
	else $error("result valid during reset");

	// An empty or draining output register always lets a new request in.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
	else $error("input stalled although the output drains");

	// An accepted request passes the stage one register and reaches the output
	// register when the output is free to move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
	else $error("accepted request did not reach the output");

	// Registers are written only while no result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_valid)
	else $error("register written while a request is in flight");

endmodule

bind orientation_address_generator_unit oag_checker u_oag_checker (.*);

@@ test/orientation_checker_pkg.sv @@
// ----------------------------------------------------------------------------
// orientation_checker_pkg
// Prediction and checking of destination coordinates and addresses.
// The checker keeps its own copy of the plane registers and of the column and
// row counters, predicts one destination record per accepted request and
// compares every delivered record, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
package orientation_checker_pkg;

	import oag_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [ADDR_W-1:0]   addr;
		logic                done;
	} dest_rec_t;

	class orientation_checker;

		logic [DIM_W-1:0]   width_reg;
		logic [DIM_W-1:0]   height_reg;
		logic               mirror_en_reg;
		logic               mirror_axis_reg;
		logic [1:0]         rotation_reg;
		logic [PITCH_W-1:0] pitch_reg;
		logic [1:0]         sample_bytes_reg;
		logic [COORD_W-1:0] col_cnt;
		logic [COORD_W-1:0] row_cnt;
		dest_rec_t          expected_dests[$];
		int                 errors;
		int                 accepted;

		function new();
			width_reg        = DIM_W'(4096);
			height_reg       = DIM_W'(4096);
			mirror_en_reg    = 1'b0;
			mirror_axis_reg  = AXIS_ROWS;
			rotation_reg     = ROT_0;
			pitch_reg        = PITCH_W'(8192);
			sample_bytes_reg = 2'd1;
			col_cnt          = '0;
			row_cnt          = '0;
			errors           = 0;
			accepted         = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PLANE_WIDTH:      width_reg        = val[DIM_W-1:0];
				REG_PLANE_HEIGHT:     height_reg       = val[DIM_W-1:0];
				REG_MIRROR_ENABLE:    mirror_en_reg    = val[0];
				REG_MIRROR_AXIS:      mirror_axis_reg  = val[0];
				REG_ROTATION:         rotation_reg     = val[1:0];
				REG_DEST_ROW_PITCH:   pitch_reg        = val[PITCH_W-1:0];
				REG_BYTES_PER_SAMPLE: sample_bytes_reg = val[1:0];
				default: begin
				end
			endcase
		endfunction

		function int effective_dim(logic [DIM_W-1:0] v);
			if (v == '0)
				return 1;
			if (int'(v) > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function int pending();
			return expected_dests.size();
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s);
			int        w;
			int        h;
			int        bytes;
			int        x;
			int        y;
			int        dx;
			int        dy;
			longint    addr;
			dest_rec_t d;
			w     = effective_dim(width_reg);
			h     = effective_dim(height_reg);
			bytes = (sample_bytes_reg >= 2'd2) ? 2 : 1;
			if (int'(col_cnt) >= w)
				col_cnt = '0;
			if (int'(row_cnt) >= h)
				row_cnt = '0;
			x = int'(col_cnt);
			y = int'(row_cnt);
			if (mirror_en_reg) begin
				if (mirror_axis_reg == AXIS_ROWS)
					y = h - 1 - y;
				else
					x = w - 1 - x;
			end
			case (rotation_reg)
				ROT_90: begin
					dx = y;
					dy = w - 1 - x;
				end
				ROT_180: begin
					dx = w - 1 - x;
					dy = h - 1 - y;
				end
				ROT_270: begin
					dx = h - 1 - y;
					dy = x;
				end
				default: begin
					dx = x;
					dy = y;
				end
			endcase
			d.done = (int'(col_cnt) == w - 1) && (int'(row_cnt) == h - 1);
			if (int'(col_cnt) == w - 1) begin
				col_cnt = '0;
				if (int'(row_cnt) == h - 1)
					row_cnt = '0;
				else
					row_cnt = row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
			addr     = longint'(pitch_reg) * longint'(dy) + longint'(dx) * longint'(bytes);
			d.sample = s;
			d.x      = dx[COORD_W-1:0];
			d.y      = dy[COORD_W-1:0];
			d.addr   = addr[ADDR_W-1:0];
			expected_dests.push_back(d);
			accepted++;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_dest(logic [SAMPLE_W-1:0] sample, logic [COORD_W-1:0] x,
				logic [COORD_W-1:0] y, logic [ADDR_W-1:0] addr, logic done);
			dest_rec_t d;
			if (expected_dests.size() == 0) begin
				report_mismatch("result delivered with no request pending");
			end else begin
				d = expected_dests.pop_front();
				if (sample !== d.sample)
					report_mismatch($sformatf("out_sample got %h expected %h", sample, d.sample));
				if (x !== d.x)
					report_mismatch($sformatf("dest_x got %0d expected %0d", x, d.x));
				if (y !== d.y)
					report_mismatch($sformatf("dest_y got %0d expected %0d", y, d.y));
				if (addr !== d.addr)
					report_mismatch($sformatf("dest_address got %h expected %h", addr, d.addr));
				if (done !== d.done)
					report_mismatch($sformatf("plane_done got %b expected %b", done, d.done));
			end
		endtask

	endclass

endpackage

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the orientation address generator.
// A short directed run covers the size, pitch and sample size extremes and
// every mirror and rotation setting, then random planes with random register
// settings follow. The sender works in bursts and the receiver stalls on
// changing patterns, with one long receiver hold and one mid-plane drain.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import oag_pkg::*;
	import orientation_checker_pkg::*;

	typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                  clk          = 1'b0;
	logic                  arst_n;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   pixel_sample = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [SAMPLE_W-1:0]   out_sample;
	logic [COORD_W-1:0]    dest_x;
	logic [COORD_W-1:0]    dest_y;
	logic [ADDR_W-1:0]     dest_address;
	logic                  plane_done;

	orientation_checker sb;
	bit                 long_hold_req = 1'b0;

	orientation_address_generator_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_sample (pixel_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_sample   (out_sample),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.dest_address (dest_address),
		.plane_done   (plane_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_dest(out_sample, dest_x, dest_y, dest_address, plane_done);
	end

	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       cycle;
		mode      = RX_ALWAYS;
		mode_left = 0;
		cycle     = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				@(negedge clk);
				case (mode)
					RX_ALWAYS:   out_ready <= 1'b1;
					RX_HALF:     out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					default:     out_ready <= ((cycle % 5) != 0);
				endcase
				cycle++;
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		@(negedge clk);
		in_valid     <= 1'b1;
		pixel_sample <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(s);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk) in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic settle_outputs();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic program_plane(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic me, input logic ma, input logic [1:0] rot,
			input logic [PITCH_W-1:0] pitch, input logic [1:0] bytes);
		write_reg(REG_PLANE_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_PLANE_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_MIRROR_ENABLE, CFG_DATA_W'(me));
		write_reg(REG_MIRROR_AXIS, CFG_DATA_W'(ma));
		write_reg(REG_ROTATION, CFG_DATA_W'(rot));
		write_reg(REG_DEST_ROW_PITCH, CFG_DATA_W'(pitch));
		write_reg(REG_BYTES_PER_SAMPLE, CFG_DATA_W'(bytes));
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n, input bit no_gaps, input bit pause_mid);
		int                  burst_left;
		int                  k;
		logic [SAMPLE_W-1:0] s;
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				settle_outputs();
			k = $urandom_range(0, 7);
			if (k == 0)
				s = '0;
			else if (k == 1)
				s = '1;
			else
				s = SAMPLE_W'($urandom_range(0, 65535));
			send_sample(s);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (!no_gaps && $urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 12));
			end
		end
		settle_outputs();
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return DIM_W'(4096);
			2:       return DIM_W'(8191);
			3:       return DIM_W'($urandom_range(4097, 8191));
			4:       return DIM_W'($urandom_range(9, 4096));
			default: return DIM_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [PITCH_W-1:0] pick_pitch();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return PITCH_W'($urandom_range(1, 64));
			default: return PITCH_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int  phase;
		int  n;
		bit  no_gaps;
		sb = new();
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_sample('0);
		send_sample('1);
		settle_outputs();
		program_plane('0, '0, 1'b0, AXIS_ROWS, ROT_0, '0, 2'd0);
		run_phase(2, 1'b1, 1'b0);
		program_plane(DIM_W'(8191), DIM_W'(8191), 1'b0, AXIS_ROWS, ROT_180, '1, 2'd3);
		run_phase(2, 1'b1, 1'b0);
		program_plane(DIM_W'(3), DIM_W'(2), 1'b1, ~AXIS_ROWS, ROT_90, PITCH_W'(100), 2'd2);
		run_phase(6, 1'b0, 1'b0);
		program_plane(DIM_W'(3), DIM_W'(2), 1'b1, AXIS_ROWS, ROT_270, PITCH_W'(37), 2'd1);
		run_phase(6, 1'b0, 1'b0);
		program_plane(DIM_W'(4096), DIM_W'(5), 1'b1, ~AXIS_ROWS, ROT_0, '1, 2'd2);
		run_phase(3, 1'b1, 1'b0);

		phase = 0;
		while (sb.accepted < 1820) begin
			phase++;
			program_plane(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_pitch(),
				2'($urandom_range(0, 3)));
			n       = $urandom_range(1, 60);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase == 8) begin
				long_hold_req = 1'b1;
				n             = 150;
				no_gaps       = 1'b1;
			end
			run_phase(n, no_gaps, phase == 5);
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
